FILE: src/sdf_pkg.sv
package sdf_pkg;

  localparam int MAX_OUT_CHARS_DEF = 64;
  localparam int VALUE_BITS_DEF    = 32;

  localparam int FIELD_W  = 7;
  localparam int CHAR_W   = 7;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int DAB_STAGES = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  typedef struct packed {
    logic               neg;
    logic               has_prec;
    logic [FIELD_W-1:0] prec;
    logic [FIELD_W-1:0] width;
    logic               left;
    logic               fsign;
    logic               ssign;
    logic               zpad;
  } fmt_t;

endpackage

FILE: src/signed_decimal_field_formatter.sv
// Signed decimal field formatter: the printf %d conversion as a stream of characters.
// The input channel (in_valid/in_ready) takes one transaction holding a value, a field
// width, a precision (negative means none) and the four flags. The output channel
// (out_valid/out_ready) gives the characters of the conversion, one per transaction,
// with their position in the run and last set on the final one. A run that would be
// empty (zero with precision zero, no sign and no width) produces no transaction.
// The value passes an input register, four double-dabble stages, a length stage and
// the character emitter. The emitter gives one character per cycle while the receiver
// accepts, and the next run follows the last character of a run with no gap. Up to
// seven items are held in flight. When the receiver stalls, the emitter holds its
// character; the stages behind it keep moving and stop as a whole, and in_ready falls,
// once the length stage holds an item it cannot hand over. Reset clears all valid
// bits and the emitter; no transaction is in flight after it.
module signed_decimal_field_formatter import sdf_pkg::*; #(
  parameter int MAX_OUT_CHARS = MAX_OUT_CHARS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VALUE_BITS-1:0]     value,
  input  logic [FIELD_W-1:0]               min_width,
  input  logic signed [FIELD_W-1:0]        precision,
  input  logic                             left_align,
  input  logic                             plus_sign,
  input  logic                             space_sign,
  input  logic                             pad_zeros,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [CHAR_W-1:0]                character,
  output logic [$clog2(MAX_OUT_CHARS)-1:0] position,
  output logic                             last
);

  localparam int STEP_N = (VALUE_BITS + DAB_STAGES - 1) / DAB_STAGES;
  localparam int DAB_W  = STEP_N * DAB_STAGES;
  localparam int PW     = $clog2(MAX_OUT_CHARS);
  localparam logic [FIELD_W-1:0] WMAX = FIELD_W'(MAX_OUT_CHARS);
  localparam logic [FIELD_W-1:0] PMAX = FIELD_W'(MAX_OUT_CHARS - 1);

  logic adv;

  // Input stage.
  logic                  s0_valid;
  fmt_t                  s0_fmt;
  logic [DAB_W-1:0]      s0_mag;
  logic [VALUE_BITS-1:0] mag_in;
  fmt_t                  fmt_in;

  always_comb begin
    mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    fmt_in.neg      = value[VALUE_BITS-1];
    fmt_in.has_prec = !precision[FIELD_W-1];
    fmt_in.prec     = precision[FIELD_W-1] ? '0 :
                      ((precision > PMAX) ? PMAX : precision);
    fmt_in.width    = (min_width > WMAX) ? WMAX : min_width;
    fmt_in.left     = left_align;
    fmt_in.fsign    = plus_sign;
    fmt_in.ssign    = space_sign;
    fmt_in.zpad     = pad_zeros;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_fmt <= fmt_in;
      s0_mag <= DAB_W'(mag_in);
    end
  end

  // Double-dabble stages.
  logic [BCD_W-1:0] d_bcd [DAB_STAGES+1];
  logic [DAB_W-1:0] d_bin [DAB_STAGES+1];
  logic             d_valid [DAB_STAGES+1];
  fmt_t             d_fmt [DAB_STAGES+1];

  assign d_bcd[0]   = '0;
  assign d_bin[0]   = s0_mag;
  assign d_valid[0] = s0_valid;
  assign d_fmt[0]   = s0_fmt;

  for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
    sdf_dabble #(.STEPS(STEP_N), .BIN_W(DAB_W)) u_dab (
      .clk    (clk),
      .en     (adv),
      .bcd_in (d_bcd[g]),
      .bin_in (d_bin[g]),
      .bcd_out(d_bcd[g+1]),
      .bin_out(d_bin[g+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[g+1] <= 1'b0;
      end else if (adv) begin
        d_valid[g+1] <= d_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_fmt[g+1] <= d_fmt[g];
      end
    end
  end

  // Length stage: phase boundaries of the run.
  logic [BCD_W-1:0]   l_bcd;
  fmt_t               l_fmt;
  logic [FIELD_W-1:0] ndig, sign_len, zeros, body, pad, lead, trail;
  logic [FIELD_W-1:0] n_e1, n_e2, n_e3, n_e4, n_total;
  logic [CHAR_W-1:0]  n_sign;

  assign l_bcd = d_bcd[DAB_STAGES];
  assign l_fmt = d_fmt[DAB_STAGES];

  always_comb begin
    ndig = FIELD_W'(1);
    for (int d = 1; d < DIGITS; d++) begin
      if (l_bcd[4*d +: 4] != 4'd0) begin
        ndig = FIELD_W'(d + 1);
      end
    end
    if (l_fmt.has_prec && l_fmt.prec == '0 && l_bcd == '0) begin
      ndig = '0;
    end
    sign_len = FIELD_W'(l_fmt.neg || l_fmt.fsign || l_fmt.ssign);
    n_sign = l_fmt.neg ? CH_MINUS : (l_fmt.fsign ? CH_PLUS : CH_SPACE);
    zeros = (l_fmt.has_prec && l_fmt.prec > ndig) ? l_fmt.prec - ndig : '0;
    body = sign_len + zeros + ndig;
    pad = (l_fmt.width > body) ? l_fmt.width - body : '0;
    if (l_fmt.zpad && !l_fmt.has_prec && !l_fmt.left) begin
      zeros = zeros + pad;
      pad = '0;
    end
    lead  = l_fmt.left ? '0 : pad;
    trail = l_fmt.left ? pad : '0;
    n_e1 = lead;
    n_e2 = n_e1 + sign_len;
    n_e3 = n_e2 + zeros;
    n_e4 = n_e3 + ndig;
    n_total = n_e4 + trail;
  end

  logic               s5_valid;
  logic [BCD_W-1:0]   s5_bcd;
  logic [CHAR_W-1:0]  s5_sign;
  logic [FIELD_W-1:0] s5_e1, s5_e2, s5_e3, s5_e4, s5_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= d_valid[DAB_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_bcd   <= l_bcd;
      s5_sign  <= n_sign;
      s5_e1    <= n_e1;
      s5_e2    <= n_e2;
      s5_e3    <= n_e3;
      s5_e4    <= n_e4;
      s5_total <= n_total;
    end
  end

  // Character emitter.
  logic               busy;
  logic [PW-1:0]      k;
  logic [BCD_W-1:0]   e_bcd;
  logic [CHAR_W-1:0]  e_sign;
  logic [FIELD_W-1:0] e1, e2, e3, e4, total;
  logic               can_emit, last_now, take;
  logic [FIELD_W-1:0] k_ext, didx;
  logic [CHAR_W-1:0]  ch;

  assign can_emit = !out_valid || out_ready;
  assign k_ext    = FIELD_W'(k);
  assign last_now = (k_ext + 1'b1) == total;
  assign take     = s5_valid && (!busy || (can_emit && last_now));
  assign adv      = !s5_valid || take;
  assign in_ready = adv;

  always_comb begin
    didx = e4 - 1'b1 - k_ext;
    if (k_ext < e1) begin
      ch = CH_SPACE;
    end else if (k_ext < e2) begin
      ch = e_sign;
    end else if (k_ext < e3) begin
      ch = CH_ZERO;
    end else if (k_ext < e4) begin
      ch = CH_ZERO + CHAR_W'(e_bcd[4*didx[3:0] +: 4]);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid <= busy;
      end
      if (take) begin
        busy <= s5_total != '0;
        k    <= '0;
      end else if (can_emit && busy) begin
        k <= k + 1'b1;
        if (last_now) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && busy) begin
      character <= ch;
      position  <= k;
      last      <= last_now;
    end
    if (take) begin
      e_bcd  <= s5_bcd;
      e_sign <= s5_sign;
      e1     <= s5_e1;
      e2     <= s5_e2;
      e3     <= s5_e3;
      e4     <= s5_e4;
      total  <= s5_total;
    end
  end

  a_ready_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s5_valid && busy)
    else $error("input stalled without a held item");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("run interrupted before its last character");

  a_position_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> position == $past(position) + 1'b1)
    else $error("position did not advance by one");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || position == '0)
    else $error("new run does not start at position zero");

endmodule

FILE: src/sdf_dabble.sv
module sdf_dabble import sdf_pkg::*; #(
  parameter int STEPS = 8,
  parameter int BIN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [BCD_W-1:0] bcd_in,
  input  logic [BIN_W-1:0] bin_in,
  output logic [BCD_W-1:0] bcd_out,
  output logic [BIN_W-1:0] bin_out
);

  logic [BCD_W-1:0] bcd;
  logic [BIN_W-1:0] bin;

  always_comb begin
    bcd = bcd_in;
    bin = bin_in;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_out <= bcd;
      bin_out <= bin;
    end
  end

endmodule
